@@ rtl/tilt_pkg.sv @@
package tilt_pkg;

    localparam int IN_W          = 16;
    localparam int ANGLE_W       = 16;
    localparam int ACC_FRAC      = 20;
    localparam int CORDIC_STEPS  = 20;
    localparam int PRE_SHIFT     = 14;
    // operands after pre-shift plus room for CORDIC gain and quadrant fold
    localparam int XY_W          = IN_W + PRE_SHIFT + 2;
    // Q.20 accumulator, covers +-(pi/2 + sum of table)
    localparam int ACC_W         = ACC_FRAC + 3;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam logic signed [ACC_W-1:0] PI_Q      = ACC_W'(3294199);
    localparam logic signed [ACC_W-1:0] HALF_PI_Q = ACC_W'(1647099);

    localparam logic [ACC_FRAC-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451,
        20'd32757,  20'd16383,  20'd8192,   20'd4096,   20'd2048,
        20'd1024,   20'd512,    20'd256,    20'd128,    20'd64,
        20'd32,     20'd16,     20'd8,      20'd4,      20'd2
    };

    // operand cases that bypass the iterations
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_PI,
        SPEC_HALF_POS,
        SPEC_HALF_NEG
    } spec_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        spec_t                   spec;
    } cordic_t;

    typedef struct packed {
        logic signed [IN_W-1:0] accel_x;
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
    } tilt_in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } tilt_out_t;

endpackage

@@ rtl/tilt_pre.sv @@
module tilt_pre
    import tilt_pkg::*;
(
    input  logic                   clk,
    input  logic signed [IN_W-1:0] num,
    input  logic signed [IN_W-1:0] den,
    output cordic_t                cell_out
);

    logic signed [XY_W-1:0] nw;
    logic signed [XY_W-1:0] dw;
    cordic_t                cell_next;
    cordic_t                cell_reg;

    assign nw = XY_W'(num) <<< PRE_SHIFT;
    assign dw = XY_W'(den) <<< PRE_SHIFT;

    always_comb
    begin
        cell_next.x    = dw;
        cell_next.y    = nw;
        cell_next.acc  = '0;
        cell_next.spec = SPEC_NONE;
        // fold the left half-plane into the right one
        if (den < 0)
        begin
            if (num >= 0)
            begin
                cell_next.x   = nw;
                cell_next.y   = -dw;
                cell_next.acc = HALF_PI_Q;
            end
            else
            begin
                cell_next.x   = -nw;
                cell_next.y   = dw;
                cell_next.acc = -HALF_PI_Q;
            end
        end
        if (num == '0)
        begin
            cell_next.spec = (den < 0) ? SPEC_PI : SPEC_ZERO;
        end
        else if (den == '0)
        begin
            cell_next.spec = (num > 0) ? SPEC_HALF_POS : SPEC_HALF_NEG;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

@@ rtl/tilt_cell.sv @@
module tilt_cell
    import tilt_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  cordic_t cell_in,
    output cordic_t cell_out
);

    localparam logic signed [ACC_W-1:0] TAB = ACC_W'(ATAN_TAB[STEP]);

    logic signed [XY_W-1:0]  x_in;
    logic signed [XY_W-1:0]  y_in;
    logic signed [ACC_W-1:0] acc_in;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    cordic_t                 cell_next;
    cordic_t                 cell_reg;

    assign x_in   = cell_in.x;
    assign y_in   = cell_in.y;
    assign acc_in = cell_in.acc;
    assign dx     = y_in >>> STEP;
    assign dy     = x_in >>> STEP;

    always_comb
    begin
        cell_next.spec = cell_in.spec;
        if (y_in >= 0)
        begin
            cell_next.x   = x_in + dx;
            cell_next.y   = y_in - dy;
            cell_next.acc = acc_in + TAB;
        end
        else
        begin
            cell_next.x   = x_in - dx;
            cell_next.y   = y_in + dy;
            cell_next.acc = acc_in - TAB;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

@@ rtl/tilt_post.sv @@
module tilt_post
    import tilt_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter bit NEGATE          = 1'b0
)
(
    input  logic                      clk,
    input  cordic_t                   cell_in,
    output logic signed [ANGLE_W-1:0] angle
);

    localparam int S = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (S - 1);

    logic signed [ACC_W-1:0]   acc_in;
    logic signed [ACC_W-1:0]   pick;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [ANGLE_W-1:0] rounded;
    logic signed [ANGLE_W-1:0] angle_next;
    logic signed [ANGLE_W-1:0] angle_reg;

    assign acc_in = cell_in.acc;

    always_comb
    begin
        case (cell_in.spec)
            SPEC_NONE:
            begin
                if (acc_in > PI_Q)
                    pick = PI_Q;
                else if (acc_in < -PI_Q)
                    pick = -PI_Q;
                else
                    pick = acc_in;
            end
            SPEC_ZERO:     pick = '0;
            SPEC_PI:       pick = PI_Q;
            SPEC_HALF_POS: pick = HALF_PI_Q;
            SPEC_HALF_NEG: pick = -HALF_PI_Q;
            default:       pick = '0;
        endcase
    end

    // round half up, then drop to output width
    assign sum        = pick + HALF_LSB;
    assign shifted    = sum >>> S;
    assign rounded    = shifted[ANGLE_W-1:0];
    assign angle_next = NEGATE ? -rounded : rounded;

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

@@ rtl/tilt_atan2.sv @@
module tilt_atan2
    import tilt_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter bit NEGATE          = 1'b0
)
(
    input  logic                      clk,
    input  logic signed [IN_W-1:0]    num,
    input  logic signed [IN_W-1:0]    den,
    output logic signed [ANGLE_W-1:0] angle
);

    cordic_t link [CORDIC_STEPS+1];

    tilt_pre u_pre
    (
        .clk      (clk),
        .num      (num),
        .den      (den),
        .cell_out (link[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        tilt_cell #(
            .STEP (i)
        ) u_cell
        (
            .clk      (clk),
            .cell_in  (link[i]),
            .cell_out (link[i+1])
        );
    end

    tilt_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE          (NEGATE)
    ) u_post
    (
        .clk     (clk),
        .cell_in (link[CORDIC_STEPS]),
        .angle   (angle)
    );

endmodule

@@ rtl/accel_tilt_angles.sv @@
// Channel  Ports                  Beat
// -------  ---------------------  -----------------------------------------
// in       start, busy, sample    taken when start is high and busy is low
// out      done, result           one cycle strobe, cannot be held off
//
// A new sample can be taken every cycle; busy never rises.
// Each beat's result shows with done once it has passed one fold
// stage, 20 CORDIC cells per angle, and one clamp and round stage.
// Reset clears only the done pipeline; the datapath runs freely.
// The three angles run in three parallel cell chains.
module accel_tilt_angles
    import tilt_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tilt_in_t  sample,
    output logic      done,
    output tilt_out_t result
);

    localparam int LAT = CORDIC_STEPS + 2;
    localparam logic signed [ANGLE_W-1:0] PI_OUT =
        ANGLE_W'((PI_Q + (ACC_W'(1) <<< (ACC_FRAC - ANGLE_FRAC_BITS - 1)))
                 >>> (ACC_FRAC - ANGLE_FRAC_BITS));

    logic           accept;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    tilt_atan2 #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE          (1'b1)
    ) u_roll
    (
        .clk   (clk),
        .num   (sample.accel_y),
        .den   (sample.accel_z),
        .angle (result.roll_angle)
    );

    tilt_atan2 #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE          (1'b0)
    ) u_pitch
    (
        .clk   (clk),
        .num   (sample.accel_x),
        .den   (sample.accel_z),
        .angle (result.pitch_angle)
    );

    tilt_atan2 #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE          (1'b0)
    ) u_yaw
    (
        .clk   (clk),
        .num   (sample.accel_y),
        .den   (sample.accel_x),
        .angle (result.yaw_angle)
    );

    // advance the beat marks alongside the cells
    assign valid_next = {valid_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign done = valid_reg[LAT-1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result strobe missing after accepted beat");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without accepted beat");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.roll_angle <= PI_OUT && result.roll_angle >= -PI_OUT
                  && result.pitch_angle <= PI_OUT && result.pitch_angle >= -PI_OUT
                  && result.yaw_angle <= PI_OUT && result.yaw_angle >= -PI_OUT))
        else $error("angle outside -pi..pi");

endmodule
